### rtl/core/rgm_pkg.sv
// Shared types and constants of the regularised Gram matrix block.
// Depends on nothing; rgm_ctrl, rgm_dp and the top level import it.
`timescale 1ns / 1ps

package rgm_pkg;

  // Samples per storage word: one per bank, four multiply-accumulates a cycle.
  localparam int unsigned LANES     = 4;
  localparam int unsigned WORD_CNT_W = 7;   // cols_in_use / LANES, up to 127
  localparam int unsigned VALUE_MAX = 32767;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    REG_RHO   = 2'd0,
    REG_COLS  = 2'd1,
    REG_ROWS  = 2'd2,
    REG_SHIFT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_RESULT
  } state_e;

  typedef struct packed {
    act_e               action;
    logic [4:0]         x_row;
    logic [7:0]         x_col;
    logic signed [7:0]  sample;
    logic [4:0]         y_row;
    logic [4:0]         y_col;
  } in_word_t;

  typedef struct packed {
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic signed [15:0] value;
    logic               clipped;
    logic               bad_request;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] rho;
    logic [8:0]         cols_in_use;
    logic [5:0]         rows_in_use;
    logic [4:0]         out_shift;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic                  write;
    logic                  start;
    logic                  issue;
    logic [WORD_CNT_W-1:0] word;
    logic                  round;
    logic                  fill;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic                  req_bad;
    logic [WORD_CNT_W-1:0] n_words;
    logic                  pipe_busy;
    logic                  out_free;
  } sts_t;

endpackage

### rtl/core/rgm_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Payload type is a parameter; the block uses the structs of rgm_pkg.
`timescale 1ns / 1ps

interface rgm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/rgm_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/core/rgm_ctrl.sv
// Sequencer of the Gram matrix block: accepts words, walks the column
// words of a read and steps the datapath. Depends on rgm_pkg.
`timescale 1ns / 1ps

module rgm_ctrl import rgm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_read_i,
  output logic in_ready_o,
  input  sts_t status_i,
  output cmd_t cmd_o
);

  state_e                state_q, state_d;
  logic [WORD_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_CNT_W-1:0] nwords_q, nwords_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      nwords_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      nwords_q <= nwords_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    nwords_d   = nwords_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_read_i) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            nwords_d    = status_i.n_words;
            state_d     = status_i.req_bad ? ST_RESULT : ST_RUN;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (cnt_q != nwords_q) begin
          cmd_o.issue = 1'b1;
          cmd_o.word  = cnt_q;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.fill = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= nwords_q))
    else $error("word counter ran past the column count");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !status_i.pipe_busy)
    else $error("word accepted while the MAC pipeline still holds data");

  a_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> status_i.pipe_busy)
    else $error("issued column word did not enter the pipeline");

endmodule

### rtl/core/rgm_dp.sv
// Datapath: four sample banks, 4-lane multiply-accumulate, rounding,
// shift and clip, output register. Depends on rgm_pkg, rgm_ram, rgm_stream_if.
`timescale 1ns / 1ps

module rgm_dp import rgm_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      status_o,
  rgm_stream_if.source out_if
);

  localparam int unsigned WPR   = (MAX_COLS + LANES - 1) / LANES;
  localparam int unsigned DEPTH = MAX_ROWS * WPR;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [6:0]  MAX_ROWS_W = 7'(MAX_ROWS);
  localparam logic [10:0] MAX_COLS_W = 11'(MAX_COLS);

  // Request check and load range.
  logic req_bad, load_ok;
  assign req_bad = (cfg_i.cols_in_use[1:0] != 2'b00)
                || ({2'b00, cfg_i.cols_in_use} > MAX_COLS_W)
                || ({1'b0, in_word_i.y_row} >= cfg_i.rows_in_use)
                || ({1'b0, in_word_i.y_col} >= cfg_i.rows_in_use)
                || ({2'b00, in_word_i.y_row} >= MAX_ROWS_W)
                || ({2'b00, in_word_i.y_col} >= MAX_ROWS_W);
  assign load_ok = ({2'b00, in_word_i.x_row} < MAX_ROWS_W)
                && ({3'b000, in_word_i.x_col} < MAX_COLS_W);

  // Request registers.
  logic [4:0]  yr_q, yc_q;
  logic        bad_q;

  // Sample banks, one per lane.
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [7:0]    rd_a [LANES];
  logic [7:0]    rd_b [LANES];

  assign waddr   = AW'(int'(in_word_i.x_row) * WPR + int'(in_word_i.x_col[7:2]));
  assign raddr_a = AW'(int'(yr_q) * WPR + int'(cmd_i.word));
  assign raddr_b = AW'(int'(yc_q) * WPR + int'(cmd_i.word));

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic we;
    assign we = cmd_i.write && load_ok && (in_word_i.x_col[1:0] == 2'(b));
    rgm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bank (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (waddr),
      .wdata_i   (in_word_i.sample),
      .raddr_a_i (raddr_a),
      .raddr_b_i (raddr_b),
      .rdata_a_o (rd_a[b]),
      .rdata_b_o (rd_b[b])
    );
  end

  // MAC pipeline: read, multiply, accumulate.
  logic                     rd_vld_q, prod_vld_q;
  logic signed [15:0]       prod_q [LANES];
  logic [31:0]              acc_q, acc_d;
  logic [31:0]              rnd_q, rnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      prod_q[l] <= $signed(rd_a[l]) * $signed(rd_b[l]);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.start) begin
      acc_d = (in_word_i.y_row == in_word_i.y_col) ? cfg_i.rho : '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + 32'(prod_q[0]) + 32'(prod_q[1])
                    + 32'(prod_q[2]) + 32'(prod_q[3]);
    end
  end

  // Half an LSB of the shifted result, nothing at shift zero.
  always_comb begin
    rnd_d = rnd_q;
    if (cmd_i.round) begin
      rnd_d = (cfg_i.out_shift == 5'd0) ? acc_q
            : acc_q + (32'd1 << (cfg_i.out_shift - 5'd1));
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rnd_q <= rnd_d;
    if (cmd_i.start) begin
      yr_q  <= in_word_i.y_row;
      yc_q  <= in_word_i.y_col;
      bad_q <= req_bad;
    end
  end

  // Shift and clip into the output register.
  logic signed [31:0] shifted;
  logic               fits;
  logic signed [15:0] clip_val;
  assign shifted  = $signed(rnd_q) >>> cfg_i.out_shift;
  assign fits     = (shifted[31:15] == '0) || (shifted[31:15] == '1);
  assign clip_val = shifted[31] ? 16'sh8000 : 16'(VALUE_MAX);

  out_word_t out_q;
  logic      out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fill) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      out_q.out_row     <= yr_q;
      out_q.out_col     <= yc_q;
      out_q.bad_request <= bad_q;
      out_q.value       <= bad_q ? 16'sd0 : (fits ? shifted[15:0] : clip_val);
      out_q.clipped     <= !bad_q && !fits;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

  assign status_o.req_bad   = req_bad;
  assign status_o.n_words   = cfg_i.cols_in_use[8:2];
  assign status_o.pipe_busy = rd_vld_q || prod_vld_q;
  assign status_o.out_free  = !out_vld_q || out_if.ready;

  a_fill_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> (!out_vld_q || out_if.ready))
    else $error("result register overwritten before it was taken");

  a_drop_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_vld_q) |-> $past(out_if.ready))
    else $error("result dropped without a handshake");

  a_round_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round |-> !(rd_vld_q || prod_vld_q))
    else $error("rounding started with products still in flight");

endmodule

### rtl/core/regularized_gram_matrix_int8.sv
// Top level of the regularised Gram matrix block: register file, sequencer
// and datapath. Depends on rgm_pkg, rgm_stream_if, rgm_ctrl, rgm_dp.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake      | word
//  ---------+-----------+----------------+--------------------------------------
//  in_if    | sink      | valid / ready  | in_word_t: load a sample or read Y(i,j)
//  out_if   | source    | valid / ready  | out_word_t: one per read, none per load
//  APB      | slave     | psel / penable | rho, cols_in_use, rows_in_use, out_shift
//
// A load is written to its bank in the cycle it is accepted. A read walks
// one word of four columns per cycle through four sample banks, each with
// two read ports for rows i and j, then waits for the pipeline to drain,
// rounds and fills the result register.
// Refused reads skip the walk, the drain and the rounding.
// Reset clears control and registers only; the sample store holds nothing
// defined until written, and no clearing pass runs.
// A stalled result waits in the output register; loads and the next read
// are still taken, and that read holds in its last step until the word leaves.

module regularized_gram_matrix_int8 import rgm_pkg::*; #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Streams
  rgm_stream_if.sink   in_if,
  rgm_stream_if.source out_if
);

  // Configuration registers, written in the access phase.
  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rho         <= '0;
      cfg_q.cols_in_use <= 9'd256;
      cfg_q.rows_in_use <= 6'd32;
      cfg_q.out_shift   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_RHO:   cfg_q.rho         <= pwdata;
        REG_COLS:  cfg_q.cols_in_use <= pwdata[8:0];
        REG_ROWS:  cfg_q.rows_in_use <= pwdata[5:0];
        REG_SHIFT: cfg_q.out_shift   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended to the bus.
  always_comb begin
    unique case (reg_idx)
      REG_RHO:   prdata = cfg_q.rho;
      REG_COLS:  prdata = {23'd0, cfg_q.cols_in_use};
      REG_ROWS:  prdata = {26'd0, cfg_q.rows_in_use};
      REG_SHIFT: prdata = {27'd0, cfg_q.out_shift};
      default:   prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t status;
  logic in_ready;

  // Hold the input until the sequencer is back in idle.
  assign in_if.ready = in_ready;

  rgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_read_i  (in_if.payload.action == ACT_READ),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rgm_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_word_i (in_if.payload),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_if    (out_if)
  );

endmodule

### tb/sv/rgm_gram_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the regularised Gram matrix block: follows the register port and
// both streams, predicts every element of Y and compares it with the returned word.
// Depends on rgm_pkg and rgm_stream_if.

module rgm_gram_checker import rgm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  rgm_stream_if       in_mon,
  rgm_stream_if       out_mon,
  output int unsigned elements_due_o,
  output int unsigned fail_count_o
);

  localparam int unsigned NUM_ROWS     = 32;
  localparam int unsigned NUM_COLS     = 256;
  localparam int unsigned REPORT_LIMIT = 10;

  logic signed [7:0] x_copy [NUM_ROWS][NUM_COLS];
  cfg_t              cfg;
  out_word_t         elements_due [$];

  // Element (i,j) of X*X^T + rho*I, rounded, shifted and clipped to 16 bits.
  function automatic out_word_t gram_element(input in_word_t w);
    out_word_t          res;
    logic signed [31:0] acc;
    int                 prod;
    res         = '0;
    res.out_row = w.y_row;
    res.out_col = w.y_col;
    if (cfg.cols_in_use[1:0] != 2'b00 || cfg.cols_in_use > NUM_COLS ||
        w.y_row >= cfg.rows_in_use || w.y_col >= cfg.rows_in_use) begin
      res.bad_request = 1'b1;
      return res;
    end
    acc = (w.y_row == w.y_col) ? cfg.rho : 32'sd0;
    for (int m = 0; m < int'(cfg.cols_in_use); m++) begin
      prod = x_copy[w.y_row][m] * x_copy[w.y_col][m];
      acc  = acc + prod;
    end
    if (cfg.out_shift != 5'd0) begin
      acc = acc + (32'd1 << (cfg.out_shift - 5'd1));
    end
    acc = acc >>> cfg.out_shift;
    if (acc > 32'sd32767) begin
      res.value   = 16'(VALUE_MAX);
      res.clipped = 1'b1;
    end else if (acc < -32'sd32768) begin
      res.value   = 16'sh8000;
      res.clipped = 1'b1;
    end else begin
      res.value = acc[15:0];
    end
    return res;
  endfunction

  task automatic flag_fail(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  initial begin
    fail_count_o   = 0;
    elements_due_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    in_word_t  w;
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      cfg.rho         = 32'sd0;
      cfg.cols_in_use = 9'd256;
      cfg.rows_in_use = 6'd32;
      cfg.out_shift   = 5'd0;
      elements_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_RHO:   cfg.rho         = pwdata;
          REG_COLS:  cfg.cols_in_use = pwdata[8:0];
          REG_ROWS:  cfg.rows_in_use = pwdata[5:0];
          REG_SHIFT: cfg.out_shift   = pwdata[4:0];
          default: ;
        endcase
      end
      // Retire the returned word before taking the new request.
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (elements_due.size() == 0) begin
          flag_fail($sformatf("unexpected word: row %0d col %0d value %0d",
                              got.out_row, got.out_col, got.value));
        end else begin
          want = elements_due.pop_front();
          if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
              got.value !== want.value || got.clipped !== want.clipped ||
              got.bad_request !== want.bad_request) begin
            flag_fail($sformatf(
              "mismatch Y(%0d,%0d): expected value %0d clip %0b bad %0b, got Y(%0d,%0d) %0d %0b %0b",
              want.out_row, want.out_col, want.value, want.clipped, want.bad_request,
              got.out_row, got.out_col, got.value, got.clipped, got.bad_request));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        w = in_mon.payload;
        if (w.action == ACT_LOAD) begin
          x_copy[w.x_row][w.x_col] = w.sample;
        end else begin
          elements_due.push_back(gram_element(w));
        end
      end
    end
    elements_due_o = elements_due.size();
  end

endmodule

### tb/sv/regularized_gram_matrix_int8_tb.sv
`timescale 1ns / 1ps
// Top of the regularised Gram matrix bench: clock, reset, register writes and
// stream stimulus; the verdict comes from rgm_gram_checker.
// Depends on rgm_pkg, rgm_stream_if, rgm_gram_checker and the block itself.

module regularized_gram_matrix_int8_tb import rgm_pkg::*;;

  localparam int unsigned ROWS          = 32;
  localparam int unsigned COLS          = 256;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned MAX_GAP       = 17;
  localparam int unsigned TARGET_WORDS  = 1400;
  // Leave a little margin before touching registers.
  localparam int unsigned LOAD_SETTLE   = 4;
  // Settle time held at the end, after every element has come back.
  localparam int unsigned DRAIN_CYCLES  = 80;
  // Watchdog on the whole run, in nanoseconds.
  localparam int unsigned WATCHDOG_NS   = 2_000_000;

  // Sample mixes used when a row of X is written.
  typedef enum int {
    FILL_ANY,
    FILL_EXTREME,
    FILL_SMALL
  } fill_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rgm_stream_if #(.T(in_word_t))  in_ch ();
  rgm_stream_if #(.T(out_word_t)) out_ch ();

  int unsigned elements_due;
  int unsigned fails;
  int unsigned words_sent;

  // Which samples of X hold a defined value; reads only touch complete rows.
  bit          loaded [ROWS][COLS];
  logic [8:0]  cur_cols;
  bit          src_quiet;
  bit          snk_quiet;

  regularized_gram_matrix_int8 #(
    .MAX_ROWS(ROWS),
    .MAX_COLS(COLS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_ch),
    .out_if  (out_ch)
  );

  rgm_gram_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .elements_due_o (elements_due),
    .fail_count_o   (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("status: fail");
    $finish;
  end

  // Result side: draw a stall for every word, with occasional stretches of none.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    snk_quiet    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
      stall = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Two-phase register write: setup, then access until pready.
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid and hold until every element asked for has come back.
  task automatic drain_stream(input int unsigned settle);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (elements_due != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic configure(input logic [31:0] rho, input logic [8:0] cols,
                           input logic [5:0] rows, input logic [4:0] shift);
    drain_stream(LOAD_SETTLE);
    reg_write(REG_RHO, rho);
    reg_write(REG_COLS, 32'(cols));
    reg_write(REG_ROWS, 32'(rows));
    reg_write(REG_SHIFT, 32'(shift));
    cur_cols = cols;
  endtask

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.payload <= w;
    in_ch.valid   <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  // Unused fields of each word carry random bits so that every bit toggles.
  task automatic load_sample(input int unsigned r, input int unsigned c,
                             input logic signed [7:0] s);
    in_word_t w;
    w.action = ACT_LOAD;
    w.x_row  = 5'(r);
    w.x_col  = 8'(c);
    w.sample = s;
    w.y_row  = 5'($urandom);
    w.y_col  = 5'($urandom);
    send_word(w);
    loaded[r][c] = 1'b1;
  endtask

  task automatic read_element(input int unsigned i, input int unsigned j);
    in_word_t w;
    w.action = ACT_READ;
    w.x_row  = 5'($urandom);
    w.x_col  = 8'($urandom);
    w.sample = 8'($urandom);
    w.y_row  = 5'(i);
    w.y_col  = 5'(j);
    send_word(w);
  endtask

  task automatic noise_load();
    load_sample($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1), 8'($urandom));
  endtask

  function automatic logic signed [7:0] draw_sample(input fill_e kind);
    case (kind)
      FILL_EXTREME: return ($urandom_range(0, 2) == 0) ? 8'sh7f : 8'sh80;
      FILL_SMALL:   return 8'($urandom_range(0, 6) - 3);
      default:      return 8'($urandom);
    endcase
  endfunction

  function automatic bit row_complete(input int unsigned r);
    for (int m = 0; m < int'(cur_cols); m++) begin
      if (!loaded[r][m]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Write columns 0..cols_in_use-1 of one row, with stray loads mixed in.
  task automatic fill_row(input int unsigned r, input fill_e kind);
    for (int c = 0; c < int'(cur_cols); c++) begin
      load_sample(r, c, draw_sample(kind));
      if ($urandom_range(0, 15) == 0) noise_load();
    end
  endtask

  // Short directed opening: saturation both ways, refused rows, zero columns,
  // accumulator wrap, unaligned column count.
  task automatic directed_checks();
    configure(32'h0000_0000, 9'd4, 6'd31, 5'd0);
    for (int c = 0; c < 4; c++) begin
      load_sample(0, c, 8'sh80);
      load_sample(30, c, 8'sh7f);
    end
    read_element(0, 0);
    read_element(0, 30);
    read_element(30, 30);
    read_element(30, 0);
    read_element(31, 0);
    read_element(0, 31);
    read_element(31, 31);
    // No columns: rho alone on the diagonal, rounding at the widest shift.
    configure(32'h8000_0000, 9'd0, 6'd32, 5'd31);
    read_element(0, 0);
    read_element(0, 30);
    configure(32'h7fff_ffff, 9'd0, 6'd32, 5'd0);
    read_element(1, 1);
    // Largest rho plus a positive sum wraps the accumulator negative.
    configure(32'h7fff_ffff, 9'd4, 6'd32, 5'd0);
    read_element(0, 0);
    configure(32'h0000_0000, 9'd2, 6'd32, 5'd1);
    read_element(0, 0);
  endtask

  // One row at the full 256 columns; only the diagonal of that row is read.
  task automatic full_width_phase();
    configure(32'($urandom_range(0, 4095)), 9'd256, 6'd32, 5'd4);
    fill_row(31, FILL_ANY);
    read_element(31, 31);
    read_element(31, 31);
    configure(32'h0000_0000, 9'd256, 6'd32, 5'd0);
    read_element(31, 31);
  endtask

  task automatic random_phase();
    int unsigned n_fill;
    int unsigned n_reads;
    int unsigned i;
    int unsigned j;
    int unsigned usable [$];
    logic [8:0]  cols;
    logic [5:0]  rows;
    logic [4:0]  shift;
    logic [31:0] rho;
    case ($urandom_range(0, 3))
      0:       rows = 6'd1;
      1:       rows = 6'd32;
      default: rows = 6'($urandom_range(1, 32));
    endcase
    case ($urandom_range(0, 9))
      0:       cols = 9'd0;
      1:       cols = 9'(4 * $urandom_range(0, 63) + $urandom_range(1, 3));
      2:       cols = 9'd4;
      default: cols = 9'(4 * $urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       shift = 5'd0;
      1:       shift = 5'd31;
      default: shift = 5'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       rho = 32'h8000_0000;
      1:       rho = 32'h7fff_ffff;
      2:       rho = 32'h0000_0000;
      3:       rho = $urandom;
      default: rho = 32'($urandom_range(0, 131072)) - 32'd65536;
    endcase
    configure(rho, cols, rows, shift);

    if (cols[1:0] == 2'b00) begin
      // Well-formed sequence: complete a few rows, then read among complete rows or out of range.
      n_fill = $urandom_range(1, 3);
      repeat (n_fill) fill_row($urandom_range(0, rows - 1), fill_e'($urandom_range(0, 2)));
      for (int r = 0; r < int'(rows); r++) begin
        if (row_complete(r)) usable.push_back(r);
      end
      n_reads = $urandom_range(12, 24);
      repeat (n_reads) begin
        if (rows < 6'd32 && $urandom_range(0, 5) == 0) begin
          // Refused: at least one index at or above rows_in_use.
          i = $urandom_range(rows, ROWS - 1);
          j = $urandom_range(0, ROWS - 1);
          if ($urandom_range(0, 1) == 1) read_element(i, j);
          else read_element(j, i);
        end else begin
          i = usable[$urandom_range(0, usable.size() - 1)];
          j = ($urandom_range(0, 3) == 0) ? i : usable[$urandom_range(0, usable.size() - 1)];
          read_element(i, j);
        end
        if ($urandom_range(0, 7) == 0) noise_load();
      end
    end else begin
      // Unaligned column count: every read is refused whatever its indices.
      n_reads = $urandom_range(8, 16);
      repeat (n_reads) begin
        read_element($urandom_range(0, ROWS - 1), $urandom_range(0, ROWS - 1));
        if ($urandom_range(0, 3) == 0) noise_load();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    words_sent    = 0;
    src_quiet     = 1'b0;
    cur_cols      = 9'd256;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_checks();
    full_width_phase();
    while (words_sent < TARGET_WORDS) random_phase();

    drain_stream(DRAIN_CYCLES);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rgm_pkg.sv
rtl/core/rgm_stream_if.sv
rtl/core/rgm_ram.sv
rtl/core/rgm_ctrl.sv
rtl/core/rgm_dp.sv
rtl/core/regularized_gram_matrix_int8.sv
tb/sv/rgm_gram_checker.sv
tb/sv/regularized_gram_matrix_int8_tb.sv
